[rtl/hid_pkg.sv]
// Shared types, widths and per-level curve transforms for the Hilbert index distance block.
// No dependencies; imported by hilbert_index_distance.
package hid_pkg;

    localparam int MAX_ORDER = 16;
    localparam int ORDER_W   = 5;
    localparam int IDX_W     = 33;
    localparam int POS_W     = 2 * MAX_ORDER;
    localparam int COORD_W   = 17;
    localparam int SUMSQ_W   = 2 * COORD_W + 1;
    localparam int VAL_W     = 42;
    localparam int ROOT_W    = 20;
    localparam int DIST_W    = 20;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [ORDER_W-1:0] order_t;

    typedef struct packed {
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
    } pts_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } xy_t;

    typedef enum logic [1:0] {
        DIG_SWAP   = 2'd0,
        DIG_UP     = 2'd1,
        DIG_DIAG   = 2'd2,
        DIG_MIRROR = 2'd3
    } digit_t;

    // Level-1 pattern from the lowest quadrant digit.
    function automatic xy_t level_one(input logic [1:0] d);
        xy_t r;
        case (d)
            DIG_SWAP:   begin r.x = 17'd1; r.y = 17'd1; end
            DIG_UP:     begin r.x = 17'd1; r.y = 17'd2; end
            DIG_DIAG:   begin r.x = 17'd2; r.y = 17'd2; end
            default:    begin r.x = 17'd2; r.y = 17'd1; end
        endcase
        return r;
    endfunction

    // Place a lower-level point at level k (half side 2^(k-1)).
    function automatic xy_t map_level(input xy_t p, input logic [1:0] d, input int k);
        xy_t    r;
        coord_t h;
        h = COORD_W'(1) << (k - 1);
        case (d)
            DIG_SWAP:   begin r.x = p.y;         r.y = p.x;         end
            DIG_UP:     begin r.x = p.x;         r.y = p.y + h;     end
            DIG_DIAG:   begin r.x = p.x + h;     r.y = p.y + h;     end
            default:    begin r.x = (h << 1) + 17'd1 - p.y; r.y = h + 17'd1 - p.x; end
        endcase
        return r;
    endfunction

endpackage

[rtl/hilbert_index_distance.sv]
// Top level: Hilbert curve index-to-coordinate pipeline and rounded distance in tenths.
// Depends on hid_pkg.
//
// Fully pipelined: one transaction enters every cycle while the output is not
// stalled, and passes through 16 curve-level stages, one stage each for
// difference, squares and scaling by 100, 20 one-bit integer square root
// stages, and the rounding/output register. The whole pipeline
// advances together, so a stalled output holds every stage and in_stall rises.
// order_reg is sampled when a transaction enters; 0 acts as 1, values above
// 16 act as 16. An index outside 1..4^order gives index_error with zero fields.
module hilbert_index_distance
    import hid_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [ORDER_W-1:0] cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [IDX_W-1:0]   start_index,
    input  logic [IDX_W-1:0]   end_index,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [COORD_W-1:0] start_x,
    output logic [COORD_W-1:0] start_y,
    output logic [COORD_W-1:0] end_x,
    output logic [COORD_W-1:0] end_y,
    output logic [DIST_W-1:0]  distance_tenths,
    output logic               index_error
);

    order_t order_reg;

    // map stages
    logic   map_vld_reg [MAX_ORDER];
    logic   map_err_reg [MAX_ORDER];
    order_t map_n_reg   [MAX_ORDER];
    pos_t   map_ps_reg  [MAX_ORDER];
    pos_t   map_pe_reg  [MAX_ORDER];
    xy_t    map_s_reg   [MAX_ORDER];
    xy_t    map_e_reg   [MAX_ORDER];

    // arithmetic stages
    logic                 dif_vld_reg, sq_vld_reg, scl_vld_reg;
    logic                 dif_err_reg, sq_err_reg, scl_err_reg;
    pts_t                 dif_pts_reg, sq_pts_reg, scl_pts_reg;
    coord_t               dx_reg, dy_reg;
    logic [SUMSQ_W-1:0]   sumsq_reg;
    logic [VAL_W-1:0]     val_reg;

    // square root stages
    logic              rt_vld_reg  [ROOT_W];
    logic              rt_err_reg  [ROOT_W];
    pts_t              rt_pts_reg  [ROOT_W];
    logic [VAL_W-1:0]  rt_rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] rt_root_reg [ROOT_W];

    logic              out_vld_reg;
    logic              out_err_reg;
    pts_t              out_pts_reg;
    logic [DIST_W-1:0] out_dist_reg;

    logic              advance;
    order_t            n_eff;
    logic [IDX_W-1:0]  limit;
    logic              in_err;
    pos_t              pos_s, pos_e;
    logic [IDX_W-1:0]  s_m1, e_m1;

    assign advance  = !out_vld_reg || !out_stall;
    assign in_stall = !advance;

    always_comb
    begin
        n_eff = order_reg;
        if (order_reg == '0)
            n_eff = ORDER_W'(1);
        else if (order_reg > ORDER_W'(MAX_ORDER))
            n_eff = ORDER_W'(MAX_ORDER);
        limit  = IDX_W'(1) << {n_eff, 1'b0};
        in_err = (start_index == '0) || (end_index == '0)
                 || (start_index > limit) || (end_index > limit);
        s_m1   = start_index - IDX_W'(1);
        e_m1   = end_index - IDX_W'(1);
        pos_s  = s_m1[POS_W-1:0];
        pos_e  = e_m1[POS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            order_reg <= ORDER_W'(1);
        else if (cfg_wr_en)
            order_reg <= cfg_wr_data;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int m = 0; m < MAX_ORDER; m++)
                map_vld_reg[m] <= 1'b0;
            dif_vld_reg <= 1'b0;
            sq_vld_reg  <= 1'b0;
            scl_vld_reg <= 1'b0;
            for (int j = 0; j < ROOT_W; j++)
                rt_vld_reg[j] <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            map_vld_reg[0] <= in_valid;
            for (int m = 1; m < MAX_ORDER; m++)
                map_vld_reg[m] <= map_vld_reg[m-1];
            dif_vld_reg   <= map_vld_reg[MAX_ORDER-1];
            sq_vld_reg    <= dif_vld_reg;
            scl_vld_reg   <= sq_vld_reg;
            rt_vld_reg[0] <= scl_vld_reg;
            for (int j = 1; j < ROOT_W; j++)
                rt_vld_reg[j] <= rt_vld_reg[j-1];
            out_vld_reg <= rt_vld_reg[ROOT_W-1];
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            map_err_reg[0] <= in_err;
            map_n_reg[0]   <= n_eff;
            map_ps_reg[0]  <= pos_s;
            map_pe_reg[0]  <= pos_e;
            map_s_reg[0]   <= level_one(pos_s[1:0]);
            map_e_reg[0]   <= level_one(pos_e[1:0]);
            for (int m = 1; m < MAX_ORDER; m++)
            begin
                map_err_reg[m] <= map_err_reg[m-1];
                map_n_reg[m]   <= map_n_reg[m-1];
                map_ps_reg[m]  <= map_ps_reg[m-1];
                map_pe_reg[m]  <= map_pe_reg[m-1];
                if (32'(map_n_reg[m-1]) >= m + 1)
                begin
                    map_s_reg[m] <= map_level(map_s_reg[m-1],
                                              2'(map_ps_reg[m-1] >> (2 * m)), m + 1);
                    map_e_reg[m] <= map_level(map_e_reg[m-1],
                                              2'(map_pe_reg[m-1] >> (2 * m)), m + 1);
                end
                else
                begin
                    map_s_reg[m] <= map_s_reg[m-1];
                    map_e_reg[m] <= map_e_reg[m-1];
                end
            end

            dif_err_reg    <= map_err_reg[MAX_ORDER-1];
            dif_pts_reg.sx <= map_s_reg[MAX_ORDER-1].x;
            dif_pts_reg.sy <= map_s_reg[MAX_ORDER-1].y;
            dif_pts_reg.ex <= map_e_reg[MAX_ORDER-1].x;
            dif_pts_reg.ey <= map_e_reg[MAX_ORDER-1].y;
            dx_reg <= (map_s_reg[MAX_ORDER-1].x > map_e_reg[MAX_ORDER-1].x)
                      ? map_s_reg[MAX_ORDER-1].x - map_e_reg[MAX_ORDER-1].x
                      : map_e_reg[MAX_ORDER-1].x - map_s_reg[MAX_ORDER-1].x;
            dy_reg <= (map_s_reg[MAX_ORDER-1].y > map_e_reg[MAX_ORDER-1].y)
                      ? map_s_reg[MAX_ORDER-1].y - map_e_reg[MAX_ORDER-1].y
                      : map_e_reg[MAX_ORDER-1].y - map_s_reg[MAX_ORDER-1].y;

            sq_err_reg <= dif_err_reg;
            sq_pts_reg <= dif_pts_reg;
            sumsq_reg  <= SUMSQ_W'(34'(dx_reg) * 34'(dx_reg))
                        + SUMSQ_W'(34'(dy_reg) * 34'(dy_reg));

            // times 100 = 64 + 32 + 4
            scl_err_reg <= sq_err_reg;
            scl_pts_reg <= sq_pts_reg;
            val_reg     <= (VAL_W'(sumsq_reg) << 6) + (VAL_W'(sumsq_reg) << 5)
                         + (VAL_W'(sumsq_reg) << 2);

            for (int j = 0; j < ROOT_W; j++)
            begin
                logic [VAL_W-1:0]  rem_in, trial;
                logic [ROOT_W-1:0] root_in;
                if (j == 0)
                begin
                    rem_in  = val_reg;
                    root_in = '0;
                    rt_err_reg[j] <= scl_err_reg;
                    rt_pts_reg[j] <= scl_pts_reg;
                end
                else
                begin
                    rem_in  = rt_rem_reg[j-1];
                    root_in = rt_root_reg[j-1];
                    rt_err_reg[j] <= rt_err_reg[j-1];
                    rt_pts_reg[j] <= rt_pts_reg[j-1];
                end
                // try bit i = ROOT_W-1-j: (r + 2^i)^2 - r^2 = r*2^(i+1) + 4^i
                trial = (VAL_W'(root_in) << (ROOT_W - j))
                      + (VAL_W'(1) << (2 * (ROOT_W - 1 - j)));
                if (rem_in >= trial)
                begin
                    rt_rem_reg[j]  <= rem_in - trial;
                    rt_root_reg[j] <= root_in | (ROOT_W'(1) << (ROOT_W - 1 - j));
                end
                else
                begin
                    rt_rem_reg[j]  <= rem_in;
                    rt_root_reg[j] <= root_in;
                end
            end

            // round up when v > r*r + r, i.e. remainder above root
            out_err_reg <= rt_err_reg[ROOT_W-1];
            if (rt_err_reg[ROOT_W-1])
            begin
                out_pts_reg  <= '0;
                out_dist_reg <= '0;
            end
            else
            begin
                out_pts_reg  <= rt_pts_reg[ROOT_W-1];
                out_dist_reg <= rt_root_reg[ROOT_W-1]
                    + DIST_W'(rt_rem_reg[ROOT_W-1] > VAL_W'(rt_root_reg[ROOT_W-1]));
            end
        end
    end

    assign out_valid       = out_vld_reg;
    assign start_x         = out_pts_reg.sx;
    assign start_y         = out_pts_reg.sy;
    assign end_x           = out_pts_reg.ex;
    assign end_y           = out_pts_reg.ey;
    assign distance_tenths = out_dist_reg;
    assign index_error     = out_err_reg;

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> map_vld_reg[0])
        else $error("accepted transaction not captured");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(distance_tenths)))
        else $error("stalled result changed");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && index_error) |-> (distance_tenths == '0 && start_x == '0))
        else $error("error result not zeroed");

    a_coord: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !index_error) |-> (start_x != '0 && start_y != '0
                                          && end_x != '0 && end_y != '0))
        else $error("coordinate out of range");

endmodule
